[hdl/assert_macros.svh]
// assertion helpers, clocked on clk; VIC_ASSERT is held off while rst_n is low, VIC_ASSERT_ALWAYS is not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VIC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VIC_ASSERT(label, prop, msg)
`define VIC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[hdl/vic_pkg.sv]
package vic_pkg;

  // sizing
  localparam int NUM_SOURCES     = 32;
  localparam int PRIORITY_LEVELS = 16;
  localparam int NEST_DEPTH      = 16;

  localparam int DATA_W     = 32;
  localparam int OFF_W      = 12;
  localparam int OP_W       = 2;
  localparam int PRIO_W     = 4;
  localparam int LVL_SPAN   = 1 << PRIO_W;
  localparam int SRC_IDX_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int NEST_IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int DEPTH_W    = $clog2(NEST_DEPTH + 1);

  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(NEST_DEPTH);
  localparam logic [PRIO_W-1:0]  PRIO_MAX   = PRIO_W'(PRIORITY_LEVELS - 1);

  // request kinds
  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2
  } opcode_t;

  // register map
  localparam logic [OFF_W-1:0] REG_IRQ_STATUS = 12'h000;
  localparam logic [OFF_W-1:0] REG_FIQ_STATUS = 12'h004;
  localparam logic [OFF_W-1:0] REG_RAW_STATUS = 12'h008;
  localparam logic [OFF_W-1:0] REG_SELECT     = 12'h00C;
  localparam logic [OFF_W-1:0] REG_ENABLE     = 12'h010;
  localparam logic [OFF_W-1:0] REG_ENABLE_CLR = 12'h014;
  localparam logic [OFF_W-1:0] REG_SOFT       = 12'h018;
  localparam logic [OFF_W-1:0] REG_SOFT_CLR   = 12'h01C;
  localparam logic [OFF_W-1:0] REG_LEVEL_MASK = 12'h024;
  localparam logic [OFF_W-1:0] REG_VECT_ADDR  = 12'hF00;
  localparam logic [OFF_W-1:0] VEC_BASE       = 12'h100;
  localparam logic [OFF_W-1:0] VEC_END        = OFF_W'(32'h100 + 4 * NUM_SOURCES);
  localparam logic [OFF_W-1:0] PRIO_BASE      = 12'h200;
  localparam logic [OFF_W-1:0] PRIO_END       = OFF_W'(32'h200 + 4 * NUM_SOURCES);

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] source_lines;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_request;
    logic              fiq_request;
  } rsp_t;

  typedef struct packed {
    logic                 found;
    logic [SRC_IDX_W-1:0] idx;
    logic [PRIO_W-1:0]    lvl;
  } win_t;

endpackage

[hdl/vic_ifs.sv]
interface vic_req_if;
  logic                         valid;
  logic                         ready;
  logic [vic_pkg::OP_W-1:0]     opcode;
  logic [vic_pkg::OFF_W-1:0]    reg_offset;
  logic [vic_pkg::DATA_W-1:0]   write_data;
  logic [vic_pkg::DATA_W-1:0]   source_lines;

  modport source (output valid, opcode, reg_offset, write_data, source_lines, input ready);
  modport sink   (input valid, opcode, reg_offset, write_data, source_lines, output ready);
endinterface

interface vic_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vic_pkg::DATA_W-1:0]   read_data;
  logic                         irq_request;
  logic                         fiq_request;

  modport source (output valid, read_data, irq_request, fiq_request, input ready);
  modport sink   (input valid, read_data, irq_request, fiq_request, output ready);
endinterface

[hdl/vectored_interrupt_controller.sv]
// vectored interrupt controller, 32 sources, register-mapped
// in_req carries one request per handshake: the sampled source lines plus an
// optional register read or write (opcode 0 sample only, 1 read, 2 write)
// out_rsp returns one response per request: read data (zero unless a read),
// and the irq / fiq request levels as they stand after the request
// path: a request accepted on in_req goes through the input register, the
// state update stage and the output register before it shows on out_rsp
// throughput: one request per cycle with out_rsp.ready high; in_req.ready stays
// high while the output register drains, so back-to-back requests stream through
// reading 0xF00 takes the winning irq source, returns its vector and pushes
// its priority; writing 0xF00 pops one nesting level
// reset (rst_n low, synchronous): enables, selects, soft bits and lines clear,
// level mask all ones, vectors zero, priorities at the lowest level, nesting
// empty, pipeline empty
// when out_rsp.ready stays low the three stages fill and in_req.ready drops;
// nothing is lost and state updates halt with the pipeline
`include "assert_macros.svh"

module vectored_interrupt_controller (
  input  logic          clk,
  input  logic          rst_n,
  vic_req_if.sink       in_req,
  vic_rsp_if.source     out_rsp
);

  // controller state
  logic [vic_pkg::NUM_SOURCES-1:0]     raw_r;
  logic [vic_pkg::NUM_SOURCES-1:0]     enable_r;
  logic [vic_pkg::NUM_SOURCES-1:0]     fast_r;
  logic [vic_pkg::NUM_SOURCES-1:0]     soft_r;
  logic [vic_pkg::PRIORITY_LEVELS-1:0] lvl_mask_r;
  logic [vic_pkg::DATA_W-1:0]          vec_r   [vic_pkg::NUM_SOURCES];
  logic [vic_pkg::PRIO_W-1:0]          prio_r  [vic_pkg::NUM_SOURCES];
  logic [vic_pkg::PRIO_W-1:0]          stack_r [vic_pkg::NEST_DEPTH];
  logic [vic_pkg::DEPTH_W-1:0]         depth_r;
  logic [vic_pkg::DATA_W-1:0]          cur_vec_r;

  // next values
  logic [vic_pkg::NUM_SOURCES-1:0]     enable_nxt;
  logic [vic_pkg::NUM_SOURCES-1:0]     fast_nxt;
  logic [vic_pkg::NUM_SOURCES-1:0]     soft_nxt;
  logic [vic_pkg::PRIORITY_LEVELS-1:0] lvl_mask_nxt;
  logic [vic_pkg::DEPTH_W-1:0]         depth_nxt;
  logic [vic_pkg::DATA_W-1:0]          cur_vec_nxt;

  // pipeline
  logic                        in_v_r;
  vic_pkg::req_t               in_r;
  logic                        mid_v_r;
  logic [vic_pkg::DATA_W-1:0]  mid_rdata_r;
  logic [vic_pkg::DATA_W-1:0]  mid_rdata_nxt;
  logic                        out_v_r;
  vic_pkg::rsp_t               out_r;
  vic_pkg::rsp_t               out_nxt;

  logic out_free, mid_free, mid_go, s1_go, in_go;

  // winner search: lowest priority level first, then lowest source index
  function automatic vic_pkg::win_t pick_winner(
    input logic [vic_pkg::NUM_SOURCES-1:0]     pend,
    input logic [vic_pkg::PRIORITY_LEVELS-1:0] mask,
    input logic [vic_pkg::PRIO_W-1:0]          prio [vic_pkg::NUM_SOURCES],
    input logic [vic_pkg::DEPTH_W-1:0]         depth,
    input logic [vic_pkg::PRIO_W-1:0]          top
  );
    logic [vic_pkg::LVL_SPAN-1:0]    mask_ext;
    logic [vic_pkg::LVL_SPAN-1:0]    lvl_hit;
    logic [vic_pkg::LVL_SPAN-1:0]    lvl_1h;
    logic [vic_pkg::NUM_SOURCES-1:0] elig;
    logic [vic_pkg::NUM_SOURCES-1:0] cand;
    logic [vic_pkg::NUM_SOURCES-1:0] cand_1h;
    vic_pkg::win_t                   w;
    mask_ext = '0;
    mask_ext[vic_pkg::PRIORITY_LEVELS-1:0] = mask;
    for (int i = 0; i < vic_pkg::NUM_SOURCES; i++) begin
      elig[i] = pend[i] && mask_ext[prio[i]] && (depth == '0 || prio[i] < top)
                && (depth < vic_pkg::DEPTH_FULL);
    end
    lvl_hit = '0;
    for (int p = 0; p < vic_pkg::LVL_SPAN; p++) begin
      for (int i = 0; i < vic_pkg::NUM_SOURCES; i++) begin
        lvl_hit[p] = lvl_hit[p] | (elig[i] && prio[i] == p[vic_pkg::PRIO_W-1:0]);
      end
    end
    // isolate lowest set level, then lowest source at that level
    lvl_1h = lvl_hit & (~lvl_hit + 1'b1);
    for (int i = 0; i < vic_pkg::NUM_SOURCES; i++) begin
      cand[i] = elig[i] && lvl_1h[prio[i]];
    end
    cand_1h = cand & (~cand + 1'b1);
    w = '0;
    w.found = |elig;
    for (int i = 0; i < vic_pkg::NUM_SOURCES; i++) begin
      if (cand_1h[i]) begin
        w.idx = w.idx | i[vic_pkg::SRC_IDX_W-1:0];
      end
    end
    for (int p = 0; p < vic_pkg::LVL_SPAN; p++) begin
      if (lvl_1h[p]) begin
        w.lvl = w.lvl | p[vic_pkg::PRIO_W-1:0];
      end
    end
    return w;
  endfunction

  // handshake flow
  assign out_free = !out_v_r || out_rsp.ready;
  assign mid_go   = mid_v_r && out_free;
  assign mid_free = !mid_v_r || out_free;
  assign s1_go    = in_v_r && mid_free;
  assign in_req.ready = !in_v_r || mid_free;
  assign in_go    = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_req.ready) begin
      in_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      in_r.opcode       <= in_req.opcode;
      in_r.reg_offset   <= in_req.reg_offset;
      in_r.write_data   <= in_req.write_data;
      in_r.source_lines <= in_req.source_lines;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: decode the request, resolve the winner, update state
  // ---------------------------------------------------------------------
  logic [vic_pkg::NUM_SOURCES-1:0] raw_new, active1, pend1;
  logic [vic_pkg::DEPTH_W-1:0]     depth_m1;
  logic [vic_pkg::NEST_IDX_W-1:0]  stk_rd_idx;
  logic [vic_pkg::PRIO_W-1:0]      stk_top;
  vic_pkg::win_t                   win1;

  logic                            is_read, is_write, aligned;
  logic                            is_vec, is_prio, is_vaddr;
  logic [vic_pkg::OFF_W-1:0]       vec_diff, prio_diff;
  logic [vic_pkg::SRC_IDX_W-1:0]   vec_idx, prio_idx, vec_rd_idx;
  logic [vic_pkg::DATA_W-1:0]      vec_rd;
  logic [vic_pkg::PRIO_W-1:0]      wr_prio;
  logic                            vec_we, prio_we, push;

  assign raw_new    = in_r.source_lines[vic_pkg::NUM_SOURCES-1:0];
  assign active1    = (raw_new | soft_r) & enable_r;
  assign pend1      = active1 & ~fast_r;
  assign depth_m1   = depth_r - 1'b1;
  assign stk_rd_idx = depth_m1[vic_pkg::NEST_IDX_W-1:0];
  assign stk_top    = stack_r[stk_rd_idx];
  assign win1       = pick_winner(pend1, lvl_mask_r, prio_r, depth_r, stk_top);

  assign is_read   = in_r.opcode == vic_pkg::OP_READ;
  assign is_write  = in_r.opcode == vic_pkg::OP_WRITE;
  assign aligned   = in_r.reg_offset[1:0] == 2'b00;
  assign vec_diff  = in_r.reg_offset - vic_pkg::VEC_BASE;
  assign prio_diff = in_r.reg_offset - vic_pkg::PRIO_BASE;
  assign vec_idx   = vec_diff[vic_pkg::SRC_IDX_W+1:2];
  assign prio_idx  = prio_diff[vic_pkg::SRC_IDX_W+1:2];
  assign is_vec    = aligned && in_r.reg_offset >= vic_pkg::VEC_BASE
                     && in_r.reg_offset < vic_pkg::VEC_END;
  assign is_prio   = aligned && in_r.reg_offset >= vic_pkg::PRIO_BASE
                     && in_r.reg_offset < vic_pkg::PRIO_END;
  assign is_vaddr  = in_r.reg_offset == vic_pkg::REG_VECT_ADDR;

  // one read port on the vector table: the winner on an address read,
  // else the slot addressed by the bus
  assign vec_rd_idx = is_vaddr ? win1.idx : vec_idx;
  assign vec_rd     = vec_r[vec_rd_idx];

  // writes saturate to the lowest implemented level
  assign wr_prio = (in_r.write_data[vic_pkg::PRIO_W-1:0] > vic_pkg::PRIO_MAX)
                   ? vic_pkg::PRIO_MAX : in_r.write_data[vic_pkg::PRIO_W-1:0];

  assign vec_we  = s1_go && is_write && is_vec;
  assign prio_we = s1_go && is_write && is_prio;
  assign push    = s1_go && is_read && is_vaddr && win1.found;

  always_comb begin
    enable_nxt    = enable_r;
    fast_nxt      = fast_r;
    soft_nxt      = soft_r;
    lvl_mask_nxt  = lvl_mask_r;
    depth_nxt     = depth_r;
    cur_vec_nxt   = cur_vec_r;
    mid_rdata_nxt = '0;
    if (is_read && aligned) begin
      priority if (is_vec) begin
        mid_rdata_nxt = vec_rd;
      end else if (is_prio) begin
        mid_rdata_nxt = vic_pkg::DATA_W'(prio_r[prio_idx]);
      end else begin
        unique case (in_r.reg_offset)
          vic_pkg::REG_IRQ_STATUS: mid_rdata_nxt = vic_pkg::DATA_W'(pend1);
          vic_pkg::REG_FIQ_STATUS: mid_rdata_nxt = vic_pkg::DATA_W'(active1 & fast_r);
          vic_pkg::REG_RAW_STATUS: mid_rdata_nxt = vic_pkg::DATA_W'(raw_new | soft_r);
          vic_pkg::REG_SELECT:     mid_rdata_nxt = vic_pkg::DATA_W'(fast_r);
          vic_pkg::REG_ENABLE:     mid_rdata_nxt = vic_pkg::DATA_W'(enable_r);
          vic_pkg::REG_SOFT:       mid_rdata_nxt = vic_pkg::DATA_W'(soft_r);
          vic_pkg::REG_LEVEL_MASK: mid_rdata_nxt = vic_pkg::DATA_W'(lvl_mask_r);
          vic_pkg::REG_VECT_ADDR: begin
            // take the winner, or repeat the current vector if none
            if (win1.found) begin
              cur_vec_nxt   = vec_rd;
              depth_nxt     = depth_r + 1'b1;
              mid_rdata_nxt = vec_rd;
            end else begin
              mid_rdata_nxt = cur_vec_r;
            end
          end
          default: mid_rdata_nxt = '0;
        endcase
      end
    end else if (is_write && aligned && !is_vec && !is_prio) begin
      unique case (in_r.reg_offset)
        vic_pkg::REG_SELECT:
          fast_nxt = in_r.write_data[vic_pkg::NUM_SOURCES-1:0];
        vic_pkg::REG_ENABLE:
          enable_nxt = enable_r | in_r.write_data[vic_pkg::NUM_SOURCES-1:0];
        vic_pkg::REG_ENABLE_CLR:
          enable_nxt = enable_r & ~in_r.write_data[vic_pkg::NUM_SOURCES-1:0];
        vic_pkg::REG_SOFT:
          soft_nxt = soft_r | in_r.write_data[vic_pkg::NUM_SOURCES-1:0];
        vic_pkg::REG_SOFT_CLR:
          soft_nxt = soft_r & ~in_r.write_data[vic_pkg::NUM_SOURCES-1:0];
        vic_pkg::REG_LEVEL_MASK:
          lvl_mask_nxt = in_r.write_data[vic_pkg::PRIORITY_LEVELS-1:0];
        vic_pkg::REG_VECT_ADDR: begin
          // end of service: drop one nesting level
          cur_vec_nxt = '0;
          if (depth_r != '0) begin
            depth_nxt = depth_m1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r      <= '0;
      enable_r   <= '0;
      fast_r     <= '0;
      soft_r     <= '0;
      lvl_mask_r <= '1;
      depth_r    <= '0;
      cur_vec_r  <= '0;
      for (int i = 0; i < vic_pkg::NUM_SOURCES; i++) begin
        vec_r[i]  <= '0;
        prio_r[i] <= vic_pkg::PRIO_MAX;
      end
    end else if (s1_go) begin
      raw_r      <= raw_new;
      enable_r   <= enable_nxt;
      fast_r     <= fast_nxt;
      soft_r     <= soft_nxt;
      lvl_mask_r <= lvl_mask_nxt;
      depth_r    <= depth_nxt;
      cur_vec_r  <= cur_vec_nxt;
      if (vec_we) begin
        vec_r[vec_idx] <= in_r.write_data;
      end
      if (prio_we) begin
        prio_r[prio_idx] <= wr_prio;
      end
    end
  end

  // nesting stack has no reset: entries are written before use
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[depth_r[vic_pkg::NEST_IDX_W-1:0]] <= win1.lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
    end else if (mid_free) begin
      mid_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      mid_rdata_r <= mid_rdata_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: request levels from the state left by this request
  // ---------------------------------------------------------------------
  logic [vic_pkg::NUM_SOURCES-1:0] active2;
  vic_pkg::win_t                   win2;

  assign active2 = (raw_r | soft_r) & enable_r;
  assign win2    = pick_winner(active2 & ~fast_r, lvl_mask_r, prio_r, depth_r, stk_top);

  always_comb begin
    out_nxt.read_data   = mid_rdata_r;
    out_nxt.irq_request = win2.found;
    out_nxt.fiq_request = |(active2 & fast_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= mid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_rsp.valid       = out_v_r;
  assign out_rsp.read_data   = out_r.read_data;
  assign out_rsp.irq_request = out_r.irq_request;
  assign out_rsp.fiq_request = out_r.fiq_request;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  logic pop_go, vaddr_wr_go, s1_stall;
  assign vaddr_wr_go = s1_go && is_write && is_vaddr;
  assign pop_go      = vaddr_wr_go && depth_r != '0;
  assign s1_stall    = in_v_r && !mid_free;

  `VIC_ASSERT(a_push_grows, push |=> depth_r == $past(depth_r) + 1'b1, "push did not nest")
  `VIC_ASSERT(a_pop_shrinks, pop_go |=> depth_r == $past(depth_r) - 1'b1, "pop did not unnest")
  `VIC_ASSERT(a_pop_clears, vaddr_wr_go |=> cur_vec_r == '0, "vector kept after pop")
  `VIC_ASSERT(a_hold_nest, s1_stall |=> $stable(depth_r) && $stable(cur_vec_r), "stall moved")
  `VIC_ASSERT(a_hold_enable, s1_stall |=> $stable(enable_r), "enable moved on stall")
  `VIC_ASSERT(a_irq_room, mid_v_r && win2.found |-> depth_r < vic_pkg::DEPTH_FULL, "irq when full")

endmodule
